/* design/ffpa_pkg.sv */
// Shared types, codes and defaults of the first-fit page allocator.
package ffpa_pkg;

  // Default pool geometry
  localparam int NUM_PAGES_DEF  = 1024;
  localparam int PAGE_BYTES_DEF = 4096;

  // Transaction field widths
  localparam int KIND_W  = 2;
  localparam int BYTES_W = 32;
  localparam int IDX_W   = 10;
  localparam int STAT_W  = 2;
  localparam int MARK_W  = 2;

  // Byte accumulator: pool size in bytes, and request plus one page, both fit
  localparam int ACC_W = 33;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO_SIZE = 2'd3;

  // Page marks
  localparam logic [MARK_W-1:0] MARK_FREE = 2'd0;
  localparam logic [MARK_W-1:0] MARK_OCC  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_HDR  = 2'd2;

  // Commands to the page walker
  typedef enum logic [1:0] {
    WOP_HOLD,
    WOP_LOAD,
    WOP_SCAN,
    WOP_STEP
  } walk_op_e;

  // Walker status toward the sequencer
  typedef struct packed {
    logic hit_free;   // free run long enough ends at the evaluated page
    logic hit_hdr;    // evaluated page is a header
    logic eval_vld;   // a read result is being evaluated
    logic eval_last;  // evaluated page is the last page of the pool
    logic addr_last;  // walker address sits on the last page
  } walk_sts_t;

  // Memory strobes from the sequencer
  typedef struct packed {
    logic mark_we;
    logic mark_re;
    logic rec_we;
    logic rec_re;
  } mem_ctl_t;

endpackage

/* design/ffpa_if.sv */
// Request and response channel interfaces of the page allocator.
interface ffpa_req_if;
  logic                         valid;
  logic                         ready;
  logic [ffpa_pkg::KIND_W-1:0]  kind;
  logic [ffpa_pkg::BYTES_W-1:0] request_bytes;
  logic [ffpa_pkg::IDX_W-1:0]   page_index;

  modport source (output valid, kind, request_bytes, page_index, input ready);
  modport sink   (input valid, kind, request_bytes, page_index, output ready);
endinterface

interface ffpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ffpa_pkg::STAT_W-1:0]  status;
  logic [ffpa_pkg::IDX_W-1:0]   start_page;
  logic [ffpa_pkg::BYTES_W-1:0] byte_count;

  modport source (output valid, status, start_page, byte_count, input ready);
  modport sink   (input valid, status, start_page, byte_count, output ready);
endinterface

/* design/ffpa_store.sv */
// Page mark memory and per-header record memory, registered reads.
module ffpa_store #(
  parameter int NUM_PAGES = ffpa_pkg::NUM_PAGES_DEF
) (
  input  logic                                       clk_i,
  input  ffpa_pkg::mem_ctl_t                         ctl_i,
  input  logic [$clog2(NUM_PAGES)-1:0]               mark_addr_i,
  input  logic [ffpa_pkg::MARK_W-1:0]                mark_wdata_i,
  output logic [ffpa_pkg::MARK_W-1:0]                mark_rdata_o,
  input  logic [$clog2(NUM_PAGES)-1:0]               rec_addr_i,
  input  logic [$clog2(NUM_PAGES+1)-1:0]             rec_run_i,
  input  logic [ffpa_pkg::BYTES_W-1:0]               rec_bytes_i,
  output logic [$clog2(NUM_PAGES+1)-1:0]             rec_run_o,
  output logic [ffpa_pkg::BYTES_W-1:0]               rec_bytes_o
);
  import ffpa_pkg::*;

  localparam int RW    = $clog2(NUM_PAGES + 1);
  localparam int REC_W = RW + BYTES_W;

  logic [MARK_W-1:0] mark_mem [NUM_PAGES];
  logic [MARK_W-1:0] mark_rdata_q;
  logic [REC_W-1:0]  rec_mem [NUM_PAGES];
  logic [REC_W-1:0]  rec_rdata_q;

  // Mark memory: one access per cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.mark_we) begin
      mark_mem[mark_addr_i] <= mark_wdata_i;
    end
    if (ctl_i.mark_re) begin
      mark_rdata_q <= mark_mem[mark_addr_i];
    end
  end

  // Record memory: run length and requested bytes at the header page
  always_ff @(posedge clk_i) begin
    if (ctl_i.rec_we) begin
      rec_mem[rec_addr_i] <= {rec_run_i, rec_bytes_i};
    end
    if (ctl_i.rec_re) begin
      rec_rdata_q <= rec_mem[rec_addr_i];
    end
  end

  assign mark_rdata_o = mark_rdata_q;
  assign rec_run_o    = rec_rdata_q[REC_W-1:BYTES_W];
  assign rec_bytes_o  = rec_rdata_q[BYTES_W-1:0];

endmodule

/* design/ffpa_walk.sv */
// Page walker: shared address counter, free-run length and byte compare.
module ffpa_walk #(
  parameter int NUM_PAGES  = ffpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BYTES = ffpa_pkg::PAGE_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ffpa_pkg::walk_op_e                 op_i,
  input  logic [$clog2(NUM_PAGES)-1:0]       load_addr_i,
  input  logic [ffpa_pkg::ACC_W-1:0]         need_i,
  input  logic [ffpa_pkg::MARK_W-1:0]        mark_i,
  output logic                               issue_o,
  output logic [$clog2(NUM_PAGES)-1:0]       addr_o,
  output logic [$clog2(NUM_PAGES)-1:0]       eval_addr_o,
  output logic [$clog2(NUM_PAGES+1)-1:0]     run_o,
  output ffpa_pkg::walk_sts_t                sts_o
);
  import ffpa_pkg::*;

  localparam int PW = $clog2(NUM_PAGES);
  localparam int RW = $clog2(NUM_PAGES + 1);
  localparam logic [PW-1:0] LastPage = PW'(NUM_PAGES - 1);

  logic [PW-1:0]    addr_q;
  logic             done_q;
  logic             ev_vld_q;
  logic [PW-1:0]    ev_addr_q;
  logic [RW-1:0]    run_q;
  logic [ACC_W-1:0] acc_q;

  logic             addr_last;
  logic             mark_free;
  logic [ACC_W-1:0] acc_inc;

  // Evaluation of the page whose mark is at the memory output
  assign addr_last = (addr_q == LastPage);
  assign issue_o   = (op_i == WOP_SCAN) && !done_q;
  assign mark_free = (mark_i == MARK_FREE);
  assign acc_inc   = acc_q + ACC_W'(PAGE_BYTES);

  assign sts_o.hit_free  = ev_vld_q && mark_free && (acc_inc >= need_i);
  assign sts_o.hit_hdr   = ev_vld_q && (mark_i == MARK_HDR);
  assign sts_o.eval_vld  = ev_vld_q;
  assign sts_o.eval_last = (ev_addr_q == LastPage);
  assign sts_o.addr_last = addr_last;

  assign addr_o      = addr_q;
  assign eval_addr_o = ev_addr_q;
  assign run_o       = run_q;

  // Counter, read pipeline and run accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      done_q    <= 1'b0;
      ev_vld_q  <= 1'b0;
      ev_addr_q <= '0;
      run_q     <= '0;
      acc_q     <= '0;
    end else begin
      unique case (op_i)
        WOP_LOAD: begin
          addr_q   <= load_addr_i;
          done_q   <= 1'b0;
          ev_vld_q <= 1'b0;
          run_q    <= '0;
          acc_q    <= '0;
        end
        WOP_SCAN: begin
          ev_vld_q <= issue_o;
          if (issue_o) begin
            ev_addr_q <= addr_q;
            if (addr_last) begin
              done_q <= 1'b1;
            end else begin
              addr_q <= addr_q + PW'(1);
            end
          end
          if (ev_vld_q) begin
            if (mark_free) begin
              run_q <= run_q + RW'(1);
              acc_q <= acc_inc;
            end else begin
              run_q <= '0;
              acc_q <= '0;
            end
          end
        end
        WOP_STEP: begin
          ev_vld_q <= 1'b0;
          if (!addr_last) begin
            addr_q <= addr_q + PW'(1);
          end
        end
        WOP_HOLD: begin
          ev_vld_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* design/first_fit_page_allocator_top.sv */
// First-fit contiguous page allocator: sequencer, result register, walker and memories.
//
// One request is taken at a time; req_i.ready is high only while the block is idle.
// After reset a clearing pass writes every page mark free, with req_i.ready low.
// All work goes through one page walker on the single-port mark memory, one page
// per cycle. Allocate: a first-fit search from page 0, then marking the run of
// n + 1 pages (n pages rounded up from the byte count). Free: search from
// page_index to its header, read the header record, then clear up to n + 1
// marks. Size query: the header search and the record read. Zero-size, bad
// index and unknown kind answer without a search. A finished result sits in an
// output register, so the next request is accepted while it waits; the block
// stalls only when a second result is ready before the first is taken.
module first_fit_page_allocator_top #(
  parameter int NUM_PAGES  = ffpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BYTES = ffpa_pkg::PAGE_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffpa_req_if.sink   req_i,
  ffpa_rsp_if.source rsp_o
);
  import ffpa_pkg::*;

  localparam int PW = $clog2(NUM_PAGES);
  localparam int RW = $clog2(NUM_PAGES + 1);

  // Sequencer states
  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SRCH = 4'd2;
  localparam logic [3:0] S_MARK = 4'd3;
  localparam logic [3:0] S_FIND = 4'd4;
  localparam logic [3:0] S_RREQ = 4'd5;
  localparam logic [3:0] S_RDAT = 4'd6;
  localparam logic [3:0] S_CLR  = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic [PW-1:0]      idx_q, idx_d;
  logic [ACC_W-1:0]   need_q, need_d;
  logic [PW-1:0]      hdr_q, hdr_d;
  logic [PW-1:0]      first_q, first_d;
  logic [RW-1:0]      cnt_q, cnt_d;
  logic [STAT_W-1:0]  res_st_q, res_st_d;
  logic [IDX_W-1:0]   res_start_q, res_start_d;
  logic [BYTES_W-1:0] res_count_q, res_count_d;

  logic               out_vld_q;
  logic [STAT_W-1:0]  out_st_q;
  logic [IDX_W-1:0]   out_start_q;
  logic [BYTES_W-1:0] out_count_q;
  logic               out_load;

  walk_op_e           walk_op;
  logic [PW-1:0]      load_addr;
  logic               walk_issue;
  logic [PW-1:0]      walk_addr;
  logic [PW-1:0]      eval_addr;
  logic [RW-1:0]      walk_run;
  walk_sts_t          sts;

  mem_ctl_t           mem_ctl;
  logic [MARK_W-1:0]  mark_wdata;
  logic [MARK_W-1:0]  mark_rdata;
  logic [RW-1:0]      rec_run;
  logic [BYTES_W-1:0] rec_bytes;
  logic               idx_ok;

  ffpa_walk #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (walk_op),
    .load_addr_i (load_addr),
    .need_i      (need_q),
    .mark_i      (mark_rdata),
    .issue_o     (walk_issue),
    .addr_o      (walk_addr),
    .eval_addr_o (eval_addr),
    .run_o       (walk_run),
    .sts_o       (sts)
  );

  ffpa_store #(
    .NUM_PAGES (NUM_PAGES)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (mem_ctl),
    .mark_addr_i  (walk_addr),
    .mark_wdata_i (mark_wdata),
    .mark_rdata_o (mark_rdata),
    .rec_addr_i   (hdr_q),
    .rec_run_i    (cnt_q),
    .rec_bytes_i  (bytes_q),
    .rec_run_o    (rec_run),
    .rec_bytes_o  (rec_bytes)
  );

  assign idx_ok = (32'(req_i.page_index) < 32'(NUM_PAGES));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    bytes_d     = bytes_q;
    idx_d       = idx_q;
    need_d      = need_q;
    hdr_d       = hdr_q;
    first_d     = first_q;
    cnt_d       = cnt_q;
    res_st_d    = res_st_q;
    res_start_d = res_start_q;
    res_count_d = res_count_q;
    walk_op     = WOP_HOLD;
    load_addr   = '0;
    mem_ctl     = '0;
    mark_wdata  = MARK_FREE;

    mem_ctl.mark_re = walk_issue;

    unique case (state_q)
      S_INIT: begin
        walk_op         = WOP_STEP;
        mem_ctl.mark_we = 1'b1;
        if (sts.addr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d      = req_i.kind;
          bytes_d     = req_i.request_bytes;
          idx_d       = PW'(req_i.page_index);
          need_d      = ACC_W'(req_i.request_bytes) + ACC_W'(PAGE_BYTES);
          res_st_d    = ST_OK;
          res_start_d = '0;
          res_count_d = '0;
          unique case (req_i.kind) inside
            KIND_ALLOC: begin
              if (req_i.request_bytes == '0) begin
                res_st_d = ST_ZERO_SIZE;
                state_d  = S_RESP;
              end else begin
                walk_op   = WOP_LOAD;
                load_addr = '0;
                state_d   = S_SRCH;
              end
            end
            KIND_FREE, KIND_QUERY: begin
              if (idx_ok) begin
                walk_op   = WOP_LOAD;
                load_addr = PW'(req_i.page_index);
                state_d   = S_FIND;
              end else begin
                res_st_d = ST_NOT_FOUND;
                state_d  = S_RESP;
              end
            end
            default: begin
              res_st_d = ST_NOT_FOUND;
              state_d  = S_RESP;
            end
          endcase
        end
      end
      // First-fit search: a hit ends a free run of n + 1 pages
      S_SRCH: begin
        if (sts.hit_free) begin
          hdr_d     = eval_addr;
          cnt_d     = walk_run;
          first_d   = eval_addr - PW'(walk_run);
          walk_op   = WOP_LOAD;
          load_addr = eval_addr - PW'(walk_run);
          state_d   = S_MARK;
        end else if (sts.eval_vld && sts.eval_last) begin
          res_st_d = ST_NO_SPACE;
          state_d  = S_RESP;
        end else begin
          walk_op = WOP_SCAN;
        end
      end
      // Mark the run occupied, header last, and write its record
      S_MARK: begin
        walk_op         = WOP_STEP;
        mem_ctl.mark_we = 1'b1;
        if (walk_addr == hdr_q) begin
          mark_wdata     = MARK_HDR;
          mem_ctl.rec_we = 1'b1;
          res_start_d    = IDX_W'(first_q);
          state_d        = S_RESP;
        end else begin
          mark_wdata = MARK_OCC;
        end
      end
      // Header search from the given page
      S_FIND: begin
        if (sts.hit_hdr) begin
          hdr_d   = eval_addr;
          state_d = S_RREQ;
        end else if (sts.eval_vld && sts.eval_last) begin
          res_st_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end else begin
          walk_op = WOP_SCAN;
        end
      end
      S_RREQ: begin
        mem_ctl.rec_re = 1'b1;
        state_d        = S_RDAT;
      end
      S_RDAT: begin
        res_count_d = rec_bytes;
        if (kind_q == KIND_FREE) begin
          cnt_d     = rec_run;
          walk_op   = WOP_LOAD;
          load_addr = idx_q;
          state_d   = S_CLR;
        end else begin
          state_d = S_RESP;
        end
      end
      // Clear n + 1 marks from the given page, stopping at the pool end
      S_CLR: begin
        walk_op         = WOP_STEP;
        mem_ctl.mark_we = 1'b1;
        if ((cnt_q == '0) || sts.addr_last) begin
          state_d = S_RESP;
        end else begin
          cnt_d = cnt_q - RW'(1);
        end
      end
      S_RESP: begin
        if (!out_vld_q || rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Transaction context
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    bytes_q     <= bytes_d;
    idx_q       <= idx_d;
    need_q      <= need_d;
    hdr_q       <= hdr_d;
    first_q     <= first_d;
    cnt_q       <= cnt_d;
    res_st_q    <= res_st_d;
    res_start_q <= res_start_d;
    res_count_q <= res_count_d;
  end

  // Output register
  assign out_load = (state_q == S_RESP) && (!out_vld_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_st_q    <= res_st_q;
      out_start_q <= res_start_q;
      out_count_q <= res_count_q;
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.status     = out_st_q;
  assign rsp_o.start_page = out_start_q;
  assign rsp_o.byte_count = out_count_q;

endmodule

/* design/ffpa_checker.sv */
// Port-level assertions for the page allocator and their bind to the top level.
module ffpa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [ffpa_pkg::STAT_W-1:0]  rsp_status_i,
  input logic [ffpa_pkg::IDX_W-1:0]   rsp_start_page_i,
  input logic [ffpa_pkg::BYTES_W-1:0] rsp_byte_count_i
);
  import ffpa_pkg::*;

  // A stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_status_i) && $stable(rsp_start_page_i) && $stable(rsp_byte_count_i))
    else $error("result payload changed while stalled");

  // Every accept moves the block out of idle, so ready drops after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("second request accepted back to back");

  // Failed requests carry no page and no byte count
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_OK) |->
      (rsp_start_page_i == '0) && (rsp_byte_count_i == '0))
    else $error("failed transaction carries payload");

  // A nonzero start page comes only from a successful allocate
  a_alloc_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_start_page_i != '0) |->
      (rsp_status_i == ST_OK) && (rsp_byte_count_i == '0))
    else $error("start page reported outside allocate");

endmodule

bind first_fit_page_allocator_top ffpa_checker u_ffpa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_start_page_i (rsp_o.start_page),
  .rsp_byte_count_i (rsp_o.byte_count)
);

/* test/tb_top.sv */
// Self-checking testbench for the first-fit page allocator: directed and random traffic.
`timescale 1ns / 1ps

module tb_top;
  import ffpa_pkg::*;

  localparam int POOL_PAGES   = NUM_PAGES_DEF;
  localparam int PG_BYTES     = PAGE_BYTES_DEF;
  localparam int RANDOM_ITEMS = 265;
  // Results taken before the receiver goes quiet for a long stretch
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 3000;
  // Worst case of one request: full search plus marking the run
  localparam int DRAIN_CYCLES = 2 * POOL_PAGES + 8;
  localparam int CYCLE_LIMIT  = 3_000_000;

  // Kind code with no meaning in the block
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   start_page;
    logic [BYTES_W-1:0] byte_count;
  } alloc_result_t;

  // Page map shadow plus the FIFO of answers still owed by the block
  class alloc_scoreboard;
    logic [MARK_W-1:0]  mark     [POOL_PAGES];
    int unsigned        run_len  [POOL_PAGES];
    logic [BYTES_W-1:0] size_rec [POOL_PAGES];
    alloc_result_t      pending_q[$];
    int                 errors;

    function new();
      foreach (mark[p]) mark[p] = MARK_FREE;
      errors = 0;
    endfunction

    // Apply one accepted transaction to the page map and queue its answer
    function alloc_result_t note_request(logic [KIND_W-1:0] kind, logic [BYTES_W-1:0] bytes,
                                         logic [IDX_W-1:0] idx);
      alloc_result_t    res;
      logic [ACC_W-1:0] pages;
      int               need;
      int               run;
      int               hit;
      int               first_pg;
      int               hdr;
      res = '0;
      res.status = ST_OK;
      if (kind == KIND_ALLOC) begin
        if (bytes == '0) begin
          res.status = ST_ZERO_SIZE;
        end else begin
          // round up at 33 bits so the largest requests do not wrap
          pages = ({1'b0, bytes} + ACC_W'(PG_BYTES - 1)) / ACC_W'(PG_BYTES);
          need  = int'(pages) + 1;
          run   = 0;
          hit   = -1;
          // first fit from page 0: n pages plus the header page
          for (int p = 0; p < POOL_PAGES; p++) begin
            if (hit < 0) begin
              run = (mark[p] == MARK_FREE) ? run + 1 : 0;
              if (run == need) hit = p;
            end
          end
          if (hit >= 0) begin
            first_pg = hit + 1 - need;
            for (int p = first_pg; p < hit; p++) mark[p] = MARK_OCC;
            mark[hit]     = MARK_HDR;
            run_len[hit]  = int'(pages);
            size_rec[hit] = bytes;
            res.start_page = IDX_W'(first_pg);
          end else begin
            res.status = ST_NO_SPACE;
          end
        end
      end else if (kind == KIND_FREE || kind == KIND_QUERY) begin
        hdr = -1;
        for (int p = int'(idx); p < POOL_PAGES; p++) begin
          if (hdr < 0 && mark[p] == MARK_HDR) hdr = p;
        end
        if (hdr < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.byte_count = size_rec[hdr];
          // free clears from the given page, not the run start; stops at pool end
          if (kind == KIND_FREE) begin
            for (int p = int'(idx); p <= int'(idx) + int'(run_len[hdr]) && p < POOL_PAGES; p++)
              mark[p] = MARK_FREE;
          end
        end
      end else begin
        res.status = ST_NOT_FOUND;
      end
      pending_q.push_back(res);
      return res;
    endfunction

    task report(string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted result against the oldest expected answer
    task check_result(alloc_result_t got);
      alloc_result_t exp_r;
      if (pending_q.size() == 0) begin
        report($sformatf("result with no request outstanding: %p", got));
      end else begin
        exp_r = pending_q.pop_front();
        if (got.status !== exp_r.status)
          report($sformatf("status %0d, expected %0d", got.status, exp_r.status));
        if (got.start_page !== exp_r.start_page)
          report($sformatf("start_page %0d, expected %0d", got.start_page, exp_r.start_page));
        if (got.byte_count !== exp_r.byte_count)
          report($sformatf("byte_count 0x%08h, expected 0x%08h", got.byte_count,
                           exp_r.byte_count));
      end
    endtask
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  bit              steady = 1'b0;
  int unsigned     cycles = 0;
  alloc_scoreboard sb = new();

  ffpa_req_if req_if ();
  ffpa_rsp_if rsp_if ();

  first_fit_page_allocator_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one request, optionally after a short gap, and wait for the transaction
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [BYTES_W-1:0] bytes,
                              input logic [IDX_W-1:0] idx, output alloc_result_t predicted);
    if (!steady && $urandom_range(0, 99) < 21) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.kind          <= kind;
    req_if.request_bytes <= bytes;
    req_if.page_index    <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = sb.note_request(kind, bytes, idx);
  endtask

  // Response side: random back-pressure, one long hold-off, result checks
  initial begin : rsp_sink
    alloc_result_t got;
    int            results;
    bit            held;
    results = 0;
    held    = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got = {rsp_if.status, rsp_if.start_page, rsp_if.byte_count};
        sb.check_result(got);
        results++;
      end
      if (results == HOLD_AT && !held) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      rsp_if.ready <= steady || ($urandom_range(0, 99) >= 21);
    end
  end

  initial begin : stimulus
    alloc_result_t      predicted;
    logic [IDX_W-1:0]   live_q[$];
    logic [KIND_W-1:0]  kind;
    logic [BYTES_W-1:0] bytes;
    logic [IDX_W-1:0]   idx;
    int                 roll;
    int                 pos;
    int                 p;
    bit                 starved;
    starved = 1'b0;
    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.kind          <= KIND_ALLOC;
    req_if.request_bytes <= '0;
    req_if.page_index    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty pool: lookups miss, unknown kind, zero and oversize requests
    send_request(KIND_QUERY, '0, '0, predicted);
    send_request(KIND_FREE, '0, 10'd1023, predicted);
    send_request(KIND_RESERVED, 32'hFFFF_FFFF, 10'h3FF, predicted);
    send_request(KIND_ALLOC, '0, '0, predicted);
    send_request(KIND_ALLOC, 32'hFFFF_FFFF, '0, predicted);
    send_request(KIND_ALLOC, 32'h8000_0000, '0, predicted);
    send_request(KIND_ALLOC, 32'(POOL_PAGES * PG_BYTES), '0, predicted);
    // Whole pool in one run, then a lookup from the middle
    send_request(KIND_ALLOC, 32'((POOL_PAGES - 1) * PG_BYTES), '0, predicted);
    send_request(KIND_ALLOC, 32'd1, '0, predicted);
    send_request(KIND_QUERY, '0, 10'd1023, predicted);
    send_request(KIND_QUERY, '0, 10'd511, predicted);
    // Free from inside the run: clearing runs off the top of the pool, page 0 stays
    send_request(KIND_FREE, '0, 10'd1, predicted);
    send_request(KIND_QUERY, '0, '0, predicted);
    send_request(KIND_ALLOC, 32'(PG_BYTES), '0, predicted);
    send_request(KIND_FREE, '0, 10'd0, predicted);
    send_request(KIND_FREE, '0, 10'd2, predicted);
    // Page rounding at the boundary and a gap too small for first fit
    send_request(KIND_ALLOC, 32'd1, '0, predicted);
    send_request(KIND_ALLOC, 32'(PG_BYTES + 1), '0, predicted);
    send_request(KIND_ALLOC, 32'(2 * PG_BYTES), '0, predicted);
    send_request(KIND_QUERY, '0, 10'd3, predicted);
    send_request(KIND_FREE, '0, 10'd2, predicted);
    send_request(KIND_ALLOC, 32'(3 * PG_BYTES), '0, predicted);
    send_request(KIND_FREE, '0, 10'd0, predicted);
    send_request(KIND_FREE, '0, 10'd5, predicted);
    send_request(KIND_FREE, '0, 10'd8, predicted);

    // Random traffic: mostly allocate/free/query of live runs, some noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 120 && n < 180);
      roll   = $urandom_range(0, 99);
      bytes  = $urandom();
      idx    = IDX_W'($urandom());
      if (starved) begin
        // pool jammed: free upward from the lowest page still in use
        p = 0;
        while (p < POOL_PAGES - 1 && sb.mark[p] == MARK_FREE) p++;
        kind = KIND_FREE;
        idx  = IDX_W'(p);
      end else if (roll < 10) begin
        // unknown kind, stray free or query, or an arbitrary byte count
        case ($urandom_range(0, 3))
          0:       kind = KIND_RESERVED;
          1:       kind = KIND_FREE;
          2:       kind = KIND_QUERY;
          default: kind = KIND_ALLOC;
        endcase
      end else if (roll < 50 || live_q.size() == 0) begin
        kind = KIND_ALLOC;
        case ($urandom_range(0, 19))
          0:       bytes = '0;
          1, 2, 3: bytes = BYTES_W'($urandom_range(1, 8) * PG_BYTES + $urandom_range(0, 1));
          4:       bytes = $urandom_range(1, 200 * PG_BYTES);
          5:       bytes = $urandom_range(1, POOL_PAGES * PG_BYTES);
          default: bytes = $urandom_range(1, 6 * PG_BYTES);
        endcase
      end else begin
        pos = $urandom_range(0, live_q.size() - 1);
        idx = live_q[pos];
        if (roll < 80) begin
          kind = KIND_FREE;
          live_q.delete(pos);
        end else begin
          kind = KIND_QUERY;
        end
        // now and then start inside the run instead of at its first page
        if ($urandom_range(0, 7) == 0) idx = idx + IDX_W'($urandom_range(1, 2));
      end
      starved = 1'b0;
      send_request(kind, bytes, idx, predicted);
      if (kind == KIND_ALLOC && predicted.status == ST_OK)
        live_q.push_back(predicted.start_page);
      if (kind == KIND_ALLOC && predicted.status == ST_NO_SPACE && bytes <= 32'(16 * PG_BYTES))
        starved = 1'b1;
    end
    steady = 1'b0;
    req_if.valid <= 1'b0;

    // Drain outstanding answers, then watch for stray results
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
